>>> hw/rtl/mesg_pkg.sv
`default_nettype none
package mesg_pkg;

	localparam int COORD_BITS_DEF  = 16;
	localparam int RADIUS_BITS_DEF = 12;
	localparam int COLOR_BITS      = 32;
	localparam int EMIT_IDX_BITS   = 2;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	typedef enum logic [4:0] {
		DP_NONE,
		DP_LOAD,
		DP_SQ_RX,
		DP_SQ_RY,
		DP_RX2_RY,
		DP_INIT_R1,
		DP_SNAP,
		DP_STEP_A,
		DP_STEP_B,
		DP_R2_NX2,
		DP_R2_NXADD,
		DP_R2_MUL_RY2,
		DP_R2_YM2,
		DP_R2_MUL_RX2,
		DP_R2_ACC,
		DP_R2_FINAL,
		DP_EMIT
	} mesg_op_t;

	typedef enum logic [3:0] {
		S_WAIT,
		S_SQ_RX,
		S_SQ_RY,
		S_RX2_RY,
		S_INIT_R1,
		S_STEP_A,
		S_STEP_B,
		S_R2_NX2,
		S_R2_NXADD,
		S_R2_MUL_RY2,
		S_R2_YM2,
		S_R2_MUL_RX2,
		S_R2_ACC,
		S_R2_FINAL,
		S_EMIT
	} mesg_state_t;

	typedef struct packed {
		mesg_op_t                 op;
		logic [EMIT_IDX_BITS-1:0] emit_idx;
	} mesg_cmd_t;

	typedef struct packed {
		logic active;
		logic filled;
		logic go_r2;
		logic slot_free;
	} mesg_sts_t;

endpackage
`default_nettype wire

>>> hw/rtl/mesg_ctrl.sv
`default_nettype none
module mesg_ctrl import mesg_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	input  wire logic      operation,
	output logic           in_ready,
	input  wire mesg_sts_t sts,
	output mesg_cmd_t      cmd
);

	mesg_state_t              state_q, state_d;
	logic [EMIT_IDX_BITS-1:0] idx_q, idx_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_WAIT;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		cmd.op       = DP_NONE;
		cmd.emit_idx = idx_q;
		in_ready     = 1'b0;
		unique case (state_q)
			S_WAIT: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == OP_START) begin
						cmd.op  = DP_LOAD;
						state_d = S_SQ_RX;
					end else if (sts.active) begin
						cmd.op  = DP_SNAP;
						state_d = S_STEP_A;
					end
				end
			end
			S_SQ_RX: begin
				cmd.op  = DP_SQ_RX;
				state_d = S_SQ_RY;
			end
			S_SQ_RY: begin
				cmd.op  = DP_SQ_RY;
				state_d = S_RX2_RY;
			end
			S_RX2_RY: begin
				cmd.op  = DP_RX2_RY;
				state_d = S_INIT_R1;
			end
			S_INIT_R1: begin
				cmd.op  = DP_INIT_R1;
				state_d = S_WAIT;
			end
			S_STEP_A: begin
				cmd.op  = DP_STEP_A;
				state_d = S_STEP_B;
			end
			S_STEP_B: begin
				cmd.op  = DP_STEP_B;
				state_d = sts.go_r2 ? S_R2_NX2 : S_EMIT;
				idx_d   = '0;
			end
			S_R2_NX2: begin
				cmd.op  = DP_R2_NX2;
				state_d = S_R2_NXADD;
			end
			S_R2_NXADD: begin
				cmd.op  = DP_R2_NXADD;
				state_d = S_R2_MUL_RY2;
			end
			S_R2_MUL_RY2: begin
				cmd.op  = DP_R2_MUL_RY2;
				state_d = S_R2_YM2;
			end
			S_R2_YM2: begin
				cmd.op  = DP_R2_YM2;
				state_d = S_R2_MUL_RX2;
			end
			S_R2_MUL_RX2: begin
				cmd.op  = DP_R2_MUL_RX2;
				state_d = S_R2_ACC;
			end
			S_R2_ACC: begin
				cmd.op  = DP_R2_ACC;
				state_d = S_R2_FINAL;
			end
			S_R2_FINAL: begin
				cmd.op  = DP_R2_FINAL;
				state_d = S_EMIT;
				idx_d   = '0;
			end
			S_EMIT: begin
				if (sts.slot_free) begin
					cmd.op = DP_EMIT;
					if ((sts.filled && idx_q == EMIT_IDX_BITS'(1)) || idx_q == '1) begin
						idx_d   = '0;
						state_d = S_WAIT;
					end else begin
						idx_d = idx_q + EMIT_IDX_BITS'(1);
					end
				end
			end
			default: begin
				state_d = S_WAIT;
			end
		endcase
	end

endmodule
`default_nettype wire

>>> hw/rtl/mesg_dp.sv
`default_nettype none
module mesg_dp import mesg_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire mesg_cmd_t                     cmd,
	output mesg_sts_t                          sts,
	input  wire logic signed [COORD_BITS-1:0]  center_x,
	input  wire logic signed [COORD_BITS-1:0]  center_y,
	input  wire logic        [RADIUS_BITS-1:0] radius_x,
	input  wire logic        [RADIUS_BITS-1:0] radius_y,
	input  wire logic        [COLOR_BITS-1:0]  color,
	input  wire logic                          filled,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed      [COORD_BITS:0]    span_x,
	output logic signed      [COORD_BITS:0]    span_y,
	output logic             [RADIUS_BITS:0]   span_length,
	output logic             [COLOR_BITS-1:0]  span_color,
	output logic                               last,
	output logic                               done_res
);

	localparam int XW   = RADIUS_BITS + 2;
	localparam int SQW  = 2 * RADIUS_BITS;
	localparam int DW   = 3 * RADIUS_BITS + 4;
	localparam int DECW = 4 * RADIUS_BITS + 4;
	localparam int MW   = 2 * RADIUS_BITS + 4;
	localparam int PW   = 2 * MW;
	localparam int SPW  = COORD_BITS + 1;
	localparam int LENW = RADIUS_BITS + 1;
	localparam int SUMW = ((COORD_BITS > XW) ? COORD_BITS : XW) + 1;

	logic [RADIUS_BITS-1:0]       rx_q, ry_q;
	logic signed [COORD_BITS-1:0] ccol_q, crow_q;
	logic [COLOR_BITS-1:0]        color_q;
	logic                         fill_q, fin_q;
	logic                         active_q, region_q, ov_q;
	logic signed [XW-1:0]         px_q, py_q;
	logic [SQW-1:0]               rx2_q, ry2_q;
	logic signed [DW-1:0]         dx_q, dy_q;
	logic signed [DECW-1:0]       dec_q, acc_q, t2_q;
	logic signed [MW-1:0]         t1_q;
	logic signed [SPW-1:0]        sxp_q, sxn_q, syp_q, syn_q;
	logic [LENW-1:0]              len_q;
	logic signed [SPW-1:0]        ox_q, oy_q;
	logic [LENW-1:0]              olen_q;
	logic [COLOR_BITS-1:0]        ocol_q;
	logic                         olast_q, odone_q;

	logic signed [MW-1:0]   mul_a, mul_b, rx_m, ry_m, rx2_m, ry2_m, px_m, ym_m;
	logic signed [PW-1:0]   mul_p;
	logic signed [DW-1:0]   two_rx2, two_ry2;
	logic signed [DECW-1:0] rx2_d, ry2_d, dx_d, dy_d, rx2_qtr;
	logic signed [SUMW-1:0] ccol_s, crow_s, px_s, py_s;
	logic                   dec_neg, dec_pos, slot_free;
	logic                   emit_last;
	logic [EMIT_IDX_BITS-1:0] k;

	assign rx_m   = $signed({{(MW-RADIUS_BITS){1'b0}}, rx_q});
	assign ry_m   = $signed({{(MW-RADIUS_BITS){1'b0}}, ry_q});
	assign rx2_m  = $signed({{(MW-SQW){1'b0}}, rx2_q});
	assign ry2_m  = $signed({{(MW-SQW){1'b0}}, ry2_q});
	assign px_m   = $signed({{(MW-XW){px_q[XW-1]}}, px_q});
	assign ym_m   = $signed({{(MW-XW){py_q[XW-1]}}, py_q}) - MW'(1);

	assign two_rx2 = $signed({{(DW-SQW-1){1'b0}}, rx2_q, 1'b0});
	assign two_ry2 = $signed({{(DW-SQW-1){1'b0}}, ry2_q, 1'b0});
	assign rx2_d   = $signed({{(DECW-SQW){1'b0}}, rx2_q});
	assign ry2_d   = $signed({{(DECW-SQW){1'b0}}, ry2_q});
	assign rx2_qtr = $signed({{(DECW-SQW+2){1'b0}}, rx2_q[SQW-1:2]});
	assign dx_d    = $signed({{(DECW-DW){dx_q[DW-1]}}, dx_q});
	assign dy_d    = $signed({{(DECW-DW){dy_q[DW-1]}}, dy_q});

	assign ccol_s = $signed({{(SUMW-COORD_BITS){ccol_q[COORD_BITS-1]}}, ccol_q});
	assign crow_s = $signed({{(SUMW-COORD_BITS){crow_q[COORD_BITS-1]}}, crow_q});
	assign px_s   = $signed({{(SUMW-XW){px_q[XW-1]}}, px_q});
	assign py_s   = $signed({{(SUMW-XW){py_q[XW-1]}}, py_q});

	assign dec_neg   = dec_q[DECW-1];
	assign dec_pos   = !dec_q[DECW-1] && (dec_q != '0);
	assign slot_free = !ov_q || out_ready;
	assign k         = cmd.emit_idx;
	assign emit_last = fill_q ? k[0] : (k == '1);

	always_comb begin
		unique case (cmd.op)
			DP_SQ_RX: begin
				mul_a = rx_m;
				mul_b = rx_m;
			end
			DP_SQ_RY: begin
				mul_a = ry_m;
				mul_b = ry_m;
			end
			DP_RX2_RY: begin
				mul_a = rx2_m;
				mul_b = ry_m;
			end
			DP_R2_NX2: begin
				mul_a = px_m;
				mul_b = px_m;
			end
			DP_R2_MUL_RY2: begin
				mul_a = ry2_m;
				mul_b = t1_q;
			end
			DP_R2_YM2: begin
				mul_a = ym_m;
				mul_b = ym_m;
			end
			DP_R2_MUL_RX2: begin
				mul_a = rx2_m;
				mul_b = t1_q;
			end
			DP_R2_ACC: begin
				mul_a = rx2_m;
				mul_b = ry2_m;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			region_q <= 1'b0;
			ov_q     <= 1'b0;
		end else begin
			unique case (cmd.op)
				DP_LOAD: begin
					active_q <= 1'b0;
					region_q <= 1'b0;
				end
				DP_INIT_R1: begin
					active_q <= (rx_q != '0) && (ry_q != '0);
				end
				DP_STEP_B: begin
					if (!region_q) begin
						if (dx_q >= dy_q)
							region_q <= 1'b1;
					end else if (py_q[XW-1] || py_q == '0) begin
						active_q <= 1'b0;
					end
				end
				default: begin
				end
			endcase
			if (cmd.op == DP_EMIT)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			DP_LOAD: begin
				rx_q    <= radius_x;
				ry_q    <= radius_y;
				ccol_q  <= center_x;
				crow_q  <= center_y;
				color_q <= color;
				fill_q  <= filled;
				px_q    <= '0;
				py_q    <= $signed({{(XW-RADIUS_BITS){1'b0}}, radius_y});
				dx_q    <= '0;
			end
			DP_SQ_RX: rx2_q <= mul_p[SQW-1:0];
			DP_SQ_RY: ry2_q <= mul_p[SQW-1:0];
			DP_RX2_RY: t2_q <= mul_p[DECW-1:0];
			DP_INIT_R1: begin
				dy_q  <= {t2_q[DW-2:0], 1'b0};
				dec_q <= ry2_d - t2_q + rx2_qtr;
			end
			DP_SNAP: begin
				fin_q <= 1'b0;
				sxp_q <= SPW'(ccol_s + px_s);
				sxn_q <= SPW'(ccol_s - px_s);
				syp_q <= SPW'(crow_s + py_s);
				syn_q <= SPW'(crow_s - py_s);
				len_q <= {px_q[RADIUS_BITS-1:0], 1'b1};
			end
			DP_STEP_A: begin
				if (!region_q) begin
					dx_q <= dx_q + two_ry2;
					px_q <= px_q + XW'(1);
					if (!dec_neg) begin
						dy_q <= dy_q - two_rx2;
						py_q <= py_q - XW'(1);
					end
				end else begin
					dy_q <= dy_q - two_rx2;
					if (!dec_pos) begin
						dx_q <= dx_q + two_ry2;
						px_q <= px_q + XW'(1);
					end
				end
			end
			DP_STEP_B: begin
				if (!region_q) begin
					if (dec_neg)
						dec_q <= dec_q + dx_d + ry2_d;
					else
						dec_q <= dec_q + dx_d - dy_d + ry2_d;
				end else begin
					if (dec_pos)
						dec_q <= dec_q + rx2_d - dy_d;
					else
						dec_q <= dec_q + dx_d - dy_d + rx2_d;
					py_q <= py_q - XW'(1);
					if (py_q[XW-1] || py_q == '0)
						fin_q <= 1'b1;
				end
			end
			DP_R2_NX2: t1_q <= mul_p[MW-1:0];
			DP_R2_NXADD: t1_q <= t1_q + px_m;
			DP_R2_MUL_RY2: acc_q <= mul_p[DECW-1:0];
			DP_R2_YM2: t1_q <= mul_p[MW-1:0];
			DP_R2_MUL_RX2: t2_q <= mul_p[DECW-1:0];
			DP_R2_ACC: begin
				acc_q <= acc_q + t2_q;
				t2_q  <= mul_p[DECW-1:0];
			end
			DP_R2_FINAL: dec_q <= acc_q - t2_q;
			DP_EMIT: begin
				ocol_q  <= color_q;
				olast_q <= emit_last;
				odone_q <= emit_last && fin_q;
				if (fill_q) begin
					ox_q   <= sxn_q;
					oy_q   <= k[0] ? syn_q : syp_q;
					olen_q <= len_q;
				end else begin
					ox_q   <= k[0] ? sxn_q : sxp_q;
					oy_q   <= k[1] ? syn_q : syp_q;
					olen_q <= LENW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign sts.active    = active_q;
	assign sts.filled    = fill_q;
	assign sts.go_r2     = !region_q && (dx_q >= dy_q);
	assign sts.slot_free = slot_free;

	assign out_valid   = ov_q;
	assign span_x      = ox_q;
	assign span_y      = oy_q;
	assign span_length = olen_q;
	assign span_color  = ocol_q;
	assign last        = olast_q;
	assign done_res    = odone_q;

endmodule
`default_nettype wire

>>> hw/rtl/midpoint_ellipse_span_generator.sv
// Midpoint ellipse span generator.
// Input channel (in_valid/in_ready): operation 0 starts an ellipse from center,
// radii, color and fill mode; operation 1 runs one midpoint iteration. Output
// channel (out_valid/out_ready): one span per transaction, four one-pixel
// spans per step in outline mode, two spans of length 2x+1 in filled mode;
// last marks the final span of a step, done_res the final span of the ellipse.
// A start loads the inputs, squares both radii and forms rx^2*ry on the shared
// multiplier, then sets up the initial decision term. A step runs the snap,
// step A and step B decision updates, plus, once at the switch to region two,
// the multiplier sequence of the new decision term, then emits one span per
// cycle while the receiver takes them, each into the output register.
// A step while idle is taken and dropped. A zero radius leaves the block idle.
// A stalled receiver holds the output register and stops span emission; in_ready
// stays low until all spans of the step are handed to the output register.
// Reset clears the state machine, the active and region flags and out_valid.
`default_nettype none
module midpoint_ellipse_span_generator import mesg_pkg::*; #(
	parameter int COORD_BITS  = COORD_BITS_DEF,
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic                          operation,
	input  wire logic signed [COORD_BITS-1:0]  center_x,
	input  wire logic signed [COORD_BITS-1:0]  center_y,
	input  wire logic        [RADIUS_BITS-1:0] radius_x,
	input  wire logic        [RADIUS_BITS-1:0] radius_y,
	input  wire logic        [COLOR_BITS-1:0]  color,
	input  wire logic                          filled,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed      [COORD_BITS:0]    span_x,
	output logic signed      [COORD_BITS:0]    span_y,
	output logic             [RADIUS_BITS:0]   span_length,
	output logic             [COLOR_BITS-1:0]  span_color,
	output logic                               last,
	output logic                               done_res
);

	mesg_cmd_t cmd;
	mesg_sts_t sts;

	mesg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mesg_dp #(
		.COORD_BITS  (COORD_BITS),
		.RADIUS_BITS (RADIUS_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.center_x    (center_x),
		.center_y    (center_y),
		.radius_x    (radius_x),
		.radius_y    (radius_y),
		.color       (color),
		.filled      (filled),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.span_x      (span_x),
		.span_y      (span_y),
		.span_length (span_length),
		.span_color  (span_color),
		.last        (last),
		.done_res    (done_res)
	);

endmodule
`default_nettype wire

>>> tb/midpoint_ellipse_span_generator_tb.sv
`default_nettype none
module midpoint_ellipse_span_generator_tb;
	import mesg_pkg::*;

	localparam int CB = COORD_BITS_DEF;
	localparam int RB = RADIUS_BITS_DEF;
	localparam int TOTAL_ITEMS = 340;

	typedef struct {
		bit                     op;
		logic signed [CB-1:0]   cx;
		logic signed [CB-1:0]   cy;
		logic        [RB-1:0]   rx;
		logic        [RB-1:0]   ry;
		logic [COLOR_BITS-1:0]  color;
		bit                     fill;
	} ellipse_cmd_t;

	typedef struct {
		logic signed [CB:0]     x;
		logic signed [CB:0]     y;
		logic        [RB:0]     len;
		logic [COLOR_BITS-1:0]  color;
		logic                   lst;
		logic                   dn;
	} span_t;

	class span_scoreboard;
		span_t expected_spans[$];
		int errors;
		bit running, region_two, fill;
		longint ccol, crow, px, py, rx2, ry2, dec, dx, dy;
		logic [COLOR_BITS-1:0] color;

		function void add_span(longint sx, longint sy, longint len, bit lst, bit dn);
			span_t s;
			s.x = sx[CB:0];
			s.y = sy[CB:0];
			s.len = len[RB:0];
			s.color = color;
			s.lst = lst;
			s.dn = dn;
			expected_spans.push_back(s);
		endfunction

		function void note_item(ellipse_cmd_t c);
			longint rx, ry, x, y, nx, ym;
			bit fin;
			if (c.op == OP_START) begin
				rx = c.rx;
				ry = c.ry;
				ccol = c.cx;
				crow = c.cy;
				color = c.color;
				fill = c.fill;
				region_two = 0;
				px = 0;
				py = ry;
				rx2 = rx * rx;
				ry2 = ry * ry;
				dx = 0;
				dy = 2 * rx2 * ry;
				dec = ry2 - rx2 * ry + rx2 / 4;
				running = (rx != 0) && (ry != 0);
				return;
			end
			if (!running)
				return;
			x = px;
			y = py;
			fin = 0;
			if (!region_two) begin
				dx += 2 * ry2;
				if (dec < 0) begin
					dec += dx + ry2;
				end else begin
					py -= 1;
					dy -= 2 * rx2;
					dec += dx - dy + ry2;
				end
				px += 1;
				if (dx >= dy) begin
					nx = px;
					ym = py - 1;
					region_two = 1;
					dec = ry2 * (nx * nx + nx) + rx2 * ym * ym - rx2 * ry2;
				end
			end else begin
				dy -= 2 * rx2;
				if (dec > 0) begin
					dec += rx2 - dy;
				end else begin
					px += 1;
					dx += 2 * ry2;
					dec += dx - dy + rx2;
				end
				py -= 1;
				if (py < 0) begin
					fin = 1;
					running = 0;
				end
			end
			if (fill) begin
				add_span(ccol - x, crow + y, 2 * x + 1, 0, 0);
				add_span(ccol - x, crow - y, 2 * x + 1, 1, fin);
			end else begin
				add_span(ccol + x, crow + y, 1, 0, 0);
				add_span(ccol - x, crow + y, 1, 0, 0);
				add_span(ccol + x, crow - y, 1, 0, 0);
				add_span(ccol - x, crow - y, 1, 1, fin);
			end
		endfunction

		function void check_field(string name, logic signed [63:0] want,
				logic signed [63:0] got);
			if (got !== want) begin
				$error("%s expected %0d got %0d", name, want, got);
				errors++;
			end
		endfunction

		function void check_span(span_t got);
			span_t want;
			if (expected_spans.size() == 0) begin
				$error("unexpected span at x %0d y %0d", got.x, got.y);
				errors++;
				return;
			end
			want = expected_spans.pop_front();
			check_field("span_x", 64'(want.x), 64'(got.x));
			check_field("span_y", 64'(want.y), 64'(got.y));
			check_field("span_length", 64'(want.len), 64'(got.len));
			check_field("span_color", 64'(want.color), 64'(got.color));
			check_field("last", 64'(want.lst), 64'(got.lst));
			check_field("done_res", 64'(want.dn), 64'(got.dn));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic operation = 1'b0;
	logic signed [CB-1:0] center_x = '0;
	logic signed [CB-1:0] center_y = '0;
	logic [RB-1:0] radius_x = '0;
	logic [RB-1:0] radius_y = '0;
	logic [COLOR_BITS-1:0] color = '0;
	logic filled = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [CB:0] span_x;
	logic signed [CB:0] span_y;
	logic [RB:0] span_length;
	logic [COLOR_BITS-1:0] span_color;
	logic last;
	logic done_res;

	span_scoreboard sb;
	bit calm = 1'b0;
	int sent = 0;

	midpoint_ellipse_span_generator DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.center_x(center_x),
		.center_y(center_y),
		.radius_x(radius_x),
		.radius_y(radius_y),
		.color(color),
		.filled(filled),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.span_x(span_x),
		.span_y(span_y),
		.span_length(span_length),
		.span_color(span_color),
		.last(last),
		.done_res(done_res)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_ready <= calm || ($urandom_range(0, 99) >= 32);
	end

	always @(posedge clk) begin : take_span
		span_t s;
		if (arst_n && out_valid && out_ready) begin
			s.x = span_x;
			s.y = span_y;
			s.len = span_length;
			s.color = span_color;
			s.lst = last;
			s.dn = done_res;
			sb.check_span(s);
		end
	end

	task automatic issue(input ellipse_cmd_t c);
		while (!calm && $urandom_range(0, 99) < 32) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= c.op;
		center_x <= c.cx;
		center_y <= c.cy;
		radius_x <= c.rx;
		radius_y <= c.ry;
		color <= c.color;
		filled <= c.fill;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_item(c);
		sent++;
	endtask

	function automatic ellipse_cmd_t random_cmd(bit op);
		ellipse_cmd_t c;
		c.op = op;
		c.cx = CB'($urandom());
		c.cy = CB'($urandom());
		c.rx = RB'($urandom());
		c.ry = RB'($urandom());
		c.color = $urandom();
		c.fill = 1'($urandom_range(0, 1));
		return c;
	endfunction

	// start an ellipse, then step until it finishes or the step budget runs out
	task automatic trace(input logic signed [CB-1:0] cx, input logic signed [CB-1:0] cy,
			input logic [RB-1:0] rx, input logic [RB-1:0] ry,
			input logic [COLOR_BITS-1:0] col, input bit fill, input int max_steps);
		ellipse_cmd_t c;
		int n;
		c.op = OP_START;
		c.cx = cx;
		c.cy = cy;
		c.rx = rx;
		c.ry = ry;
		c.color = col;
		c.fill = fill;
		issue(c);
		n = 0;
		while (sb.running && n < max_steps) begin
			issue(random_cmd(OP_STEP));
			n++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.expected_spans.size() != 0);
	endtask

	function automatic logic [RB-1:0] pick_radius();
		int p;
		p = $urandom_range(0, 99);
		if (p < 4)
			return '0;
		if (p < 75)
			return RB'($urandom_range(1, 8));
		return RB'($urandom_range(9, 40));
	endfunction

	initial begin
		int r, budget;
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(random_cmd(OP_STEP));
		trace(100, -100, 0, 5, 32'h1234_5678, 1, 0);
		issue(random_cmd(OP_STEP));
		trace(-5, 7, 5, 0, 32'h8765_4321, 0, 0);
		issue(random_cmd(OP_STEP));
		trace(32767, -32768, 4095, 4095, 32'hffff_ffff, 1, 3);
		trace(-32768, 32767, 1, 4095, 32'h0000_0000, 0, 3);
		trace(0, 0, 4095, 1, 32'h5a5a_5a5a, 1, 2);
		trace(0, 0, 1, 1, 32'h00ff_00ff, 0, 10);
		issue(random_cmd(OP_STEP));
		trace(-3, 4, 2, 3, 32'hff00_ff00, 1, 20);
		drain();

		while (sent < TOTAL_ITEMS) begin
			calm <= (sent >= 140 && sent < 220);
			r = $urandom_range(0, 99);
			if (r < 8) begin
				issue(random_cmd(1'($urandom_range(0, 1))));
			end else if (r < 11) begin
				drain();
			end else begin
				budget = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 100000;
				trace(CB'($urandom()), CB'($urandom()), pick_radius(), pick_radius(),
					$urandom(), 1'($urandom_range(0, 1)), budget);
				if ($urandom_range(0, 4) == 0)
					issue(random_cmd(OP_STEP));
			end
		end
		calm <= 1'b0;
		drain();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.expected_spans.size() == 0)
			$display("midpoint_ellipse_span_generator regression: pass");
		else
			$display("midpoint_ellipse_span_generator regression: fail");
		$finish;
	end

	initial begin
		#(8 * 400000);
		$display("midpoint_ellipse_span_generator regression: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
hw/rtl/mesg_pkg.sv
hw/rtl/mesg_ctrl.sv
hw/rtl/mesg_dp.sv
hw/rtl/midpoint_ellipse_span_generator.sv
tb/midpoint_ellipse_span_generator_tb.sv
